// ----- src/krr_pkg.sv -----
package krr_pkg;

  localparam int unsigned KEY_W     = 4;
  localparam int unsigned USAGE_W   = 8;
  localparam int unsigned OUT_SLOTS = 6;

  // matrix key numbers
  localparam logic [KEY_W-1:0] KEY_UP  = 4'd0;
  localparam logic [KEY_W-1:0] KEY_DN  = 4'd1;
  localparam logic [KEY_W-1:0] KEY_LT  = 4'd2;
  localparam logic [KEY_W-1:0] KEY_RT  = 4'd3;
  localparam logic [KEY_W-1:0] KEY_MID = 4'd4;
  localparam logic [KEY_W-1:0] KEY_A   = 4'd5;
  localparam logic [KEY_W-1:0] KEY_B   = 4'd6;
  localparam logic [KEY_W-1:0] KEY_X   = 4'd7;
  localparam logic [KEY_W-1:0] KEY_Y   = 4'd8;

  // HID keyboard usage codes
  localparam logic [USAGE_W-1:0] USG_NONE   = 8'h00;
  localparam logic [USAGE_W-1:0] USG_UP     = 8'h52;
  localparam logic [USAGE_W-1:0] USG_DOWN   = 8'h51;
  localparam logic [USAGE_W-1:0] USG_LEFT   = 8'h50;
  localparam logic [USAGE_W-1:0] USG_RIGHT  = 8'h4F;
  localparam logic [USAGE_W-1:0] USG_SPACE  = 8'h2C;
  localparam logic [USAGE_W-1:0] USG_DELETE = 8'h2A;
  localparam logic [USAGE_W-1:0] USG_ENTER  = 8'h28;
  localparam logic [USAGE_W-1:0] USG_ESCAPE = 8'h29;
  localparam logic [USAGE_W-1:0] USG_TAB    = 8'h2B;

  // command bit
  localparam logic CMD_PRESS   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRESS,
    ST_REL_SCAN,
    ST_REL_PAD,
    ST_DONE
  } krr_state_e;

  typedef enum logic [1:0] {
    WSRC_USAGE,
    WSRC_VALUE,
    WSRC_ZERO
  } krr_wsrc_e;

  // compare result on the slot currently read
  typedef struct packed {
    logic hit;
    logic empty;
  } krr_match_t;

  // slot write request from the sequencer
  typedef struct packed {
    logic      en;
    krr_wsrc_e src;
  } krr_wctl_t;

  function automatic logic [USAGE_W-1:0] krr_usage(input logic [KEY_W-1:0] key);
    logic [USAGE_W-1:0] u;
    unique case (key)
      KEY_UP:  u = USG_UP;
      KEY_DN:  u = USG_DOWN;
      KEY_LT:  u = USG_LEFT;
      KEY_RT:  u = USG_RIGHT;
      KEY_MID: u = USG_SPACE;
      KEY_A:   u = USG_DELETE;
      KEY_B:   u = USG_ENTER;
      KEY_X:   u = USG_ESCAPE;
      KEY_Y:   u = USG_TAB;
      default: u = USG_NONE;
    endcase
    return u;
  endfunction

endpackage

// ----- src/krr_match.sv -----
module krr_match
  import krr_pkg::*;
(
  input  logic [USAGE_W-1:0] slot_i,
  input  logic [USAGE_W-1:0] usage_i,
  output krr_match_t         match_o
);

  // shared comparator: one slot against the event usage and against empty
  assign match_o.hit   = (slot_i == usage_i);
  assign match_o.empty = (slot_i == USG_NONE);

endmodule

// ----- src/krr_ctrl.sv -----
module krr_ctrl
  import krr_pkg::*;
#(
  parameter int unsigned SLOTS = 6,
  parameter int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int unsigned CW    = $clog2(SLOTS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          cmd_i,
  input  logic          usage_zero_i,
  input  krr_match_t    match_i,
  output logic [IW-1:0] rd_addr_o,
  output logic [IW-1:0] wr_addr_o,
  output krr_wctl_t     wctl_o,
  output logic          load_o,
  output logic          idle_o
);

  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL = CW'(SLOTS);

  krr_state_e    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] wr_q, wr_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (usage_zero_i) begin
            state_d = ST_DONE;
          end else if (cmd_i == CMD_RELEASE) begin
            state_d = ST_REL_SCAN;
          end else begin
            state_d = ST_PRESS;
          end
        end
      end
      ST_PRESS: begin
        if (match_i.hit || match_i.empty || idx_q == LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_REL_SCAN: begin
        if (idx_q == LAST) begin
          state_d = ST_REL_PAD;
        end
      end
      ST_REL_PAD: begin
        if (wr_q == FULL) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    idx_d      = idx_q;
    wr_d       = wr_q;
    wctl_o.en  = 1'b0;
    wctl_o.src = WSRC_USAGE;
    wr_addr_o  = idx_q;
    load_o     = 1'b0;
    idle_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        idx_d  = '0;
        wr_d   = '0;
      end
      ST_PRESS: begin
        // first free slot takes the usage unless it is already held
        wctl_o.en  = match_i.empty && !match_i.hit;
        wctl_o.src = WSRC_USAGE;
        wr_addr_o  = idx_q;
        idx_d      = idx_q + 1'b1;
      end
      ST_REL_SCAN: begin
        // keep every other nonzero usage, packed toward slot 0
        wctl_o.en  = !match_i.hit && !match_i.empty;
        wctl_o.src = WSRC_VALUE;
        wr_addr_o  = wr_q[IW-1:0];
        if (wctl_o.en) begin
          wr_d = wr_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
      end
      ST_REL_PAD: begin
        wctl_o.en  = (wr_q != FULL);
        wctl_o.src = WSRC_ZERO;
        wr_addr_o  = wr_q[IW-1:0];
        if (wctl_o.en) begin
          wr_d = wr_q + 1'b1;
        end
      end
      ST_DONE: load_o = 1'b1;
      default: ;
    endcase
  end

  assign rd_addr_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      wr_q    <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      wr_q    <= wr_d;
    end
  end

endmodule

// ----- src/keyboard_rollover_report_table.sv -----
// Channel   Dir  tdata (low bit up)         tuser
// s_axis    in   key[3:0], zero pad to 8     command (0 press, 1 release)
// m_axis    out  slot0[7:0] .. slot5[7:0]    -
//
// Unknown key: the sequencer goes straight to its done state and loads the unchanged slots.
// Press: the comparator walks the slots one per cycle, up to a match, an empty slot or the last slot.
// Release: a scan of every slot, then zero padding of the slots past the n usages kept.
// The sequencer uses a single slot comparator for every step.
// Reset clears the slots and all control at once. A new request is taken only
// when the sequencer is idle and the previous result has been taken.
module keyboard_rollover_report_table
  import krr_pkg::*;
#(
  parameter int unsigned SLOTS = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // key[3:0], pad
  input  logic                           s_axis_tuser,  // command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_SLOTS*USAGE_W-1:0]   m_axis_tdata   // slot0 .. slot5
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic [USAGE_W-1:0] slots_q [SLOTS];
  logic [USAGE_W-1:0] usage_q;
  logic [USAGE_W-1:0] usage_in;
  logic [USAGE_W-1:0] rd_val;
  logic [USAGE_W-1:0] wr_val;
  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      wr_addr;
  krr_match_t         match;
  krr_wctl_t          wctl;
  logic               load;
  logic               idle;
  logic               s_acc;
  logic               m_valid_q;
  logic [OUT_SLOTS*USAGE_W-1:0] m_data_q;
  logic [OUT_SLOTS*USAGE_W-1:0] report;

  assign usage_in      = krr_usage(s_axis_tdata[KEY_W-1:0]);
  assign s_axis_tready = idle && !m_valid_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign rd_val        = slots_q[rd_addr];

  krr_match u_match (
    .slot_i  (rd_val),
    .usage_i (usage_q),
    .match_o (match)
  );

  krr_ctrl #(
    .SLOTS (SLOTS),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (s_acc),
    .cmd_i        (s_axis_tuser),
    .usage_zero_i (usage_in == USG_NONE),
    .match_i      (match),
    .rd_addr_o    (rd_addr),
    .wr_addr_o    (wr_addr),
    .wctl_o       (wctl),
    .load_o       (load),
    .idle_o       (idle)
  );

  // slot write data
  always_comb begin
    unique case (wctl.src)
      WSRC_USAGE: wr_val = usage_q;
      WSRC_VALUE: wr_val = rd_val;
      WSRC_ZERO:  wr_val = USG_NONE;
      default:    wr_val = USG_NONE;
    endcase
  end

  // event usage, held for the scan
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      usage_q <= usage_in;
    end
  end

  // report slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slots_q[i] <= USG_NONE;
      end
    end else if (wctl.en) begin
      slots_q[wr_addr] <= wr_val;
    end
  end

  // report image; slots past SLOTS read as empty
  for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_report
    if (j < SLOTS) begin : g_held
      assign report[j*USAGE_W +: USAGE_W] = slots_q[j];
    end else begin : g_empty
      assign report[j*USAGE_W +: USAGE_W] = USG_NONE;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= report;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- src/krr_checker.sv -----
module krr_checker
  import krr_pkg::*;
(
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [OUT_SLOTS*USAGE_W-1:0] m_axis_tdata
);

  // a new request waits until the pending result is gone
  a_no_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  // a taken request is not followed at once by ready or a result
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && !m_axis_tvalid)
    else $error("block not busy after a request");

  // a taken result is not followed by another at once
  a_gap_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
    else $error("result repeated");

  // stalled result holds
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind keyboard_rollover_report_table krr_checker u_krr_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
  import krr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_SLOTS   = 6;
  localparam int unsigned RAND_EVENTS = 1700;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES = 40;

  localparam int unsigned REPORT_W = OUT_SLOTS * USAGE_W;

  // Tracks the held usages and the reports they should produce
  class rollover_scoreboard #(int unsigned N = 6);
    logic [USAGE_W-1:0]  held [N];
    logic [REPORT_W-1:0] expected_reports [$];
    int unsigned         fail_count;

    function new();
      foreach (held[i]) held[i] = USG_NONE;
      fail_count = 0;
    endfunction

    function logic [USAGE_W-1:0] key_usage(logic [KEY_W-1:0] key);
      case (key)
        KEY_UP:  return USG_UP;
        KEY_DN:  return USG_DOWN;
        KEY_LT:  return USG_LEFT;
        KEY_RT:  return USG_RIGHT;
        KEY_MID: return USG_SPACE;
        KEY_A:   return USG_DELETE;
        KEY_B:   return USG_ENTER;
        KEY_X:   return USG_ESCAPE;
        KEY_Y:   return USG_TAB;
        default: return USG_NONE;
      endcase
    endfunction

    // Apply one accepted key request and queue the report it causes
    function void note_event(logic cmd, logic [KEY_W-1:0] key);
      logic [USAGE_W-1:0]  usage;
      logic [REPORT_W-1:0] rpt;
      int unsigned         wr;
      usage = key_usage(key);
      if (usage != USG_NONE) begin
        if (cmd == CMD_PRESS) begin
          // first free slot, unless already held; dropped when full
          for (int i = 0; i < N; i++) begin
            if (held[i] == usage) break;
            if (held[i] == USG_NONE) begin
              held[i] = usage;
              break;
            end
          end
        end else begin
          // drop the usage and pack the rest to the front
          wr = 0;
          for (int i = 0; i < N; i++) begin
            if (held[i] != usage && held[i] != USG_NONE) begin
              held[wr] = held[i];
              wr++;
            end
          end
          for (int i = wr; i < N; i++) held[i] = USG_NONE;
        end
      end
      rpt = '0;
      for (int j = 0; j < OUT_SLOTS && j < N; j++) rpt[j*USAGE_W +: USAGE_W] = held[j];
      expected_reports.push_back(rpt);
    endfunction

    function void check_report(logic [REPORT_W-1:0] data);
      logic [REPORT_W-1:0] exp_rpt;
      if (expected_reports.size() == 0) begin
        $error("report %h with no request outstanding", data);
        fail_count++;
        return;
      end
      exp_rpt = expected_reports.pop_front();
      for (int j = 0; j < OUT_SLOTS; j++) begin
        if (data[j*USAGE_W +: USAGE_W] !== exp_rpt[j*USAGE_W +: USAGE_W]) begin
          $error("slot%0d: expected %h, actual %h", j,
                 exp_rpt[j*USAGE_W +: USAGE_W], data[j*USAGE_W +: USAGE_W]);
          fail_count++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // key[3:0], zero pad
  logic                s_axis_tuser;   // command
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [REPORT_W-1:0] m_axis_tdata;   // slot0[7:0] .. slot5[7:0]

  rollover_scoreboard #(NUM_SLOTS) sb;
  int unsigned idle_cycles;
  bit          no_idle;

  keyboard_rollover_report_table #(
    .SLOTS(NUM_SLOTS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, some long ones, none while no_idle is set
  function automatic int unsigned rand_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_event(s_axis_tuser, s_axis_tdata[KEY_W-1:0]);
      if (m_axis_tvalid && m_axis_tready) sb.check_report(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // Watchdog on cycles without any request moving
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(negedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // Result side back-pressure
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0 && !no_idle) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        stall_left = rand_gap();
      end
    end
  end

  // Called at a falling edge; returns at a falling edge
  task automatic send_event(logic cmd, logic [KEY_W-1:0] key);
    int unsigned gap;
    s_axis_tdata  = {{(8-KEY_W){1'b0}}, key};
    s_axis_tuser  = cmd;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    gap = rand_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Stop sending and wait for every outstanding report
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned press_pct;
    logic [KEY_W-1:0] key;
    logic cmd;
    sb            = new();
    idle_cycles   = 0;
    no_idle       = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_PRESS;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: fill, repeat press, overflow, unknown keys, compaction, empty release
    send_event(CMD_PRESS,   KEY_UP);
    send_event(CMD_PRESS,   KEY_UP);
    send_event(CMD_PRESS,   KEY_DN);
    send_event(CMD_PRESS,   KEY_LT);
    send_event(CMD_PRESS,   KEY_RT);
    send_event(CMD_PRESS,   KEY_MID);
    send_event(CMD_PRESS,   KEY_A);
    send_event(CMD_PRESS,   KEY_B);
    send_event(CMD_PRESS,   KEY_X);
    send_event(CMD_PRESS,   KEY_Y);
    send_event(CMD_PRESS,   4'd9);
    send_event(CMD_PRESS,   4'd15);
    send_event(CMD_RELEASE, KEY_LT);
    send_event(CMD_PRESS,   KEY_Y);
    send_event(CMD_RELEASE, KEY_B);
    send_event(CMD_RELEASE, 4'd15);
    send_event(CMD_RELEASE, KEY_UP);
    send_event(CMD_RELEASE, KEY_Y);
    send_event(CMD_RELEASE, KEY_DN);
    send_event(CMD_RELEASE, KEY_RT);
    send_event(CMD_RELEASE, KEY_MID);
    send_event(CMD_RELEASE, KEY_A);
    send_event(CMD_RELEASE, KEY_UP);
    send_event(CMD_PRESS,   KEY_X);
    send_event(CMD_RELEASE, KEY_X);

    // Random: mostly valid keys, press bias swings so slots fill and empty
    press_pct = 70;
    for (int n = 0; n < RAND_EVENTS; n++) begin
      if (n % 100 == 0) press_pct = (press_pct == 70) ? 30 : 70;
      no_idle = (n >= 400 && n < 550);
      if (n == 850) wait_drained();
      if ($urandom_range(0, 9) != 0)
        key = KEY_W'($urandom_range(KEY_UP, KEY_Y));
      else
        key = KEY_W'($urandom_range(9, 15));
      cmd = ($urandom_range(0, 99) < press_pct) ? CMD_PRESS : CMD_RELEASE;
      send_event(cmd, key);
    end
    s_axis_tvalid = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d reports never arrived", sb.pending());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
